// ----- hdl/itrd_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the ISO 15693 tag
// response decoder. No dependencies; every other file imports this package.

package itrd_pkg;

    localparam int ITRD_MAX_RAW_BYTES = 1024;
    localparam int CIB_W              = 13;
    localparam int BITPOS_W           = 13;
    localparam int RES_FIFO_DEPTH     = 4;

    localparam logic [4:0]  SOF_MASK     = 5'h1F;
    localparam logic [4:0]  SOF_PATTERN  = 5'h17;
    localparam logic [7:0]  EOF_MASK     = 8'hE0;
    localparam logic [7:0]  EOF_PATTERN  = 8'hA0;
    localparam logic [7:0]  EOF_NEXT_RAW = 8'h03;
    localparam logic [15:0] CRC_PRESET   = 16'hFFFF;
    // Bit-reversed form of the 0x1021 polynomial.
    localparam logic [15:0] CRC_POLY_REF = 16'h8408;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SOF   = 3'd1;
    localparam logic [2:0] ST_COLLISION = 3'd2;
    localparam logic [2:0] ST_BOUNDARY  = 3'd3;
    localparam logic [2:0] ST_LEN_CRC   = 3'd4;

    typedef struct packed {
        logic       kind;
        logic [7:0] decoded_byte;
        logic [2:0] status;
        logic       crc_bad;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } step_out_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REF) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- hdl/itrd_frame_core.sv -----
// Frame state and the single-pass decode of one raw byte: SOF check, up to
// seven Manchester pairs, EOF look-ahead, CRC tail tracking and status.
// Depends on itrd_pkg.

module itrd_frame_core
    import itrd_pkg::*;
#(
    parameter int MAX_RAW_BYTES = ITRD_MAX_RAW_BYTES
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CIB_W-1:0] cfg_wr_data,
    input  logic             fire,
    input  logic [7:0]       raw_byte,
    input  logic             frame_end,
    output step_out_t        step_out
);

    localparam int RAW_IDX_W = $clog2(MAX_RAW_BYTES + 1);
    localparam logic [RAW_IDX_W-1:0] RAW_IDX_MAX = RAW_IDX_W'(MAX_RAW_BYTES);
    localparam logic [1:0] MAN_ZERO = 2'b01;
    localparam logic [1:0] MAN_ONE  = 2'b10;

    logic [CIB_W-1:0]     cib_reg;
    logic [7:0]           held_raw_reg, held_raw_next;
    logic [RAW_IDX_W-1:0] raw_index_reg, raw_index_next;
    logic [BITPOS_W-1:0]  bit_pos_reg, bit_pos_next;
    logic [7:0]           partial_reg, partial_next;
    logic [15:0]          crc_reg, crc_next;
    logic [15:0]          tail_reg, tail_next;
    logic [1:0]           tail_cnt_reg, tail_cnt_next;
    logic                 stopped_reg, stopped_next;
    logic [2:0]           err_reg, err_next;

    always_comb
    begin : step_logic
        logic [7:0]          pb;
        logic [BITPOS_W-1:0] bp;
        logic                stop;
        logic [2:0]          err;
        logic                done;
        logic [7:0]          done_byte;
        logic                proc_held;
        logic                eof_here;
        logic [15:0]         pair_bits;
        logic [1:0]          man;
        logic                en;
        logic                eof_k;
        logic                is_eof;
        logic                bval;
        logic [2:0]          st;
        logic                cb;
        result_t             data_res;
        result_t             stat_res;

        pb   = partial_reg;
        bp   = bit_pos_reg;
        stop = stopped_reg;
        err  = err_reg;
        done = 1'b0;
        done_byte = 8'h00;
        proc_held = 1'b0;
        is_eof    = 1'b0;
        bval      = 1'b0;
        pair_bits = {raw_byte, held_raw_reg};

        if (!stop)
        begin
            if (raw_index_reg == '0)
            begin
                if ((raw_byte[4:0] & SOF_MASK) != SOF_PATTERN)
                begin
                    stop = 1'b1;
                    err  = ST_BAD_SOF;
                end
            end
            else if (raw_index_reg >= RAW_IDX_MAX)
            begin
                stop = 1'b1;
                err  = ST_LEN_CRC;
            end
            else
            begin
                proc_held = 1'b1;
            end
        end

        eof_here = ((held_raw_reg & EOF_MASK) == EOF_PATTERN) && (raw_byte == EOF_NEXT_RAW);

        // Four pairs start in the held byte, three more in a frame's final byte.
        // With the new byte above the held one, pair k always sits at bits 2k+1 and 2k+2.
        for (int k = 0; k < 7; k++)
        begin
            man = {pair_bits[2 + 2 * k], pair_bits[1 + 2 * k]};
            if (k < 4)
            begin
                en     = proc_held && ((raw_index_reg != RAW_IDX_W'(1)) || (k >= 2));
                eof_k  = eof_here;
            end
            else
            begin
                en     = frame_end && ((raw_index_reg != '0) || (k == 6));
                eof_k  = 1'b0;
            end

            if (en && !stop)
            begin
                if (man == MAN_ZERO || man == MAN_ONE)
                begin
                    bval = (man == MAN_ONE);
                    pb   = pb | ({7'd0, bval} << bp[2:0]);
                    bp   = bp + 1'b1;
                    if (bp[2:0] == 3'd0)
                    begin
                        done      = 1'b1;
                        done_byte = pb;
                        pb        = 8'h00;
                    end
                end
                is_eof = (bp[2:0] == 3'd0) && eof_k;
                if ((man != MAN_ZERO) && (man != MAN_ONE) && !is_eof)
                begin
                    if (bp >= cib_reg)
                    begin
                        stop = 1'b1;
                        err  = ST_COLLISION;
                    end
                    else
                    begin
                        bp = bp + 1'b1;
                        if (bp[2:0] == 3'd0)
                        begin
                            done      = 1'b1;
                            done_byte = pb;
                            pb        = 8'h00;
                        end
                    end
                end
                else if (is_eof)
                begin
                    stop = 1'b1;
                end
            end
        end

        // At most seven bits go in per byte, so at most one byte completes.
        crc_next      = crc_reg;
        tail_next     = tail_reg;
        tail_cnt_next = tail_cnt_reg;
        if (done)
        begin
            if (tail_cnt_reg >= 2'd2)
            begin
                crc_next = crc_feed(crc_reg, tail_reg[7:0]);
            end
            else
            begin
                tail_cnt_next = tail_cnt_reg + 1'b1;
            end
            tail_next = {done_byte, tail_reg[15:8]};
        end

        cb = 1'b0;
        if (err != ST_OK)
        begin
            st = err;
        end
        else if (bp[2:0] != 3'd0)
        begin
            st = ST_BOUNDARY;
        end
        else if (bp[BITPOS_W-1:3] <= (BITPOS_W-3)'(2))
        begin
            st = ST_LEN_CRC;
        end
        else if (~crc_next != tail_next)
        begin
            st = ST_LEN_CRC;
            cb = 1'b1;
        end
        else
        begin
            st = ST_OK;
        end

        data_res = '{kind: KIND_DATA, decoded_byte: done_byte, status: ST_OK,
                     crc_bad: 1'b0, last: 1'b0};
        stat_res = '{kind: KIND_STATUS, decoded_byte: 8'h00, status: st,
                     crc_bad: cb, last: 1'b1};

        step_out.r0    = done ? data_res : stat_res;
        step_out.r1    = stat_res;
        step_out.count = fire ? ({1'b0, done} + {1'b0, frame_end}) : 2'd0;

        if (frame_end)
        begin
            held_raw_next  = 8'h00;
            raw_index_next = '0;
            bit_pos_next   = '0;
            partial_next   = 8'h00;
            crc_next       = CRC_PRESET;
            tail_next      = 16'h0000;
            tail_cnt_next  = 2'd0;
            stopped_next   = 1'b0;
            err_next       = ST_OK;
        end
        else
        begin
            held_raw_next  = raw_byte;
            raw_index_next = (raw_index_reg < RAW_IDX_MAX) ? raw_index_reg + 1'b1
                                                           : raw_index_reg;
            bit_pos_next   = bp;
            partial_next   = pb;
            stopped_next   = stop;
            err_next       = err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cib_reg       <= '0;
            held_raw_reg  <= 8'h00;
            raw_index_reg <= '0;
            bit_pos_reg   <= '0;
            partial_reg   <= 8'h00;
            crc_reg       <= CRC_PRESET;
            tail_reg      <= 16'h0000;
            tail_cnt_reg  <= 2'd0;
            stopped_reg   <= 1'b0;
            err_reg       <= ST_OK;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cib_reg <= cfg_wr_data;
            end
            if (fire)
            begin
                held_raw_reg  <= held_raw_next;
                raw_index_reg <= raw_index_next;
                bit_pos_reg   <= bit_pos_next;
                partial_reg   <= partial_next;
                crc_reg       <= crc_next;
                tail_reg      <= tail_next;
                tail_cnt_reg  <= tail_cnt_next;
                stopped_reg   <= stopped_next;
                err_reg       <= err_next;
            end
        end
    end

endmodule

// ----- hdl/itrd_result_fifo.sv -----
// Result queue that takes up to two results per cycle and hands out one when
// out_ready is set. It is the decoder's output register. Depends on itrd_pkg.

module itrd_result_fifo
    import itrd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  step_out_t push,
    output logic      room,
    output logic      out_valid,
    input  logic      out_ready,
    output result_t   out_res
);

    localparam int PTR_W = $clog2(RES_FIFO_DEPTH);
    localparam int CNT_W = $clog2(RES_FIFO_DEPTH + 1);

    result_t            mem_reg [RES_FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    assign out_valid = (count_reg != '0);
    assign out_res   = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // Room for a full step is decided from registered state only.
    assign room      = (count_reg <= CNT_W'(RES_FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + 1'b1] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hdl/iso15693_tag_response_decoder.sv -----
// Top level of the ISO 15693 tag response decoder: input register, frame
// core and result queue. Depends on itrd_pkg, itrd_frame_core, itrd_result_fifo.
//
//   channel  | direction | tdata                        | tuser | tlast
//   ---------+-----------+------------------------------+-------+-----------
//   s_*      | in        | raw_byte                     | -     | frame_end
//   m_*      | out       | decoded_byte, status, crc_bad| kind  | last
//   cfg_*    | in        | collision_ignore_bits        | -     | -
//
// A raw byte is taken every cycle while the queue has room: it is held in the
// input register, then one pass of the frame core writes its results into the
// result queue. A final byte that also completes a data byte gives two results,
// which the queue drains at one per cycle while m_tready is high; input stalls
// only when the queue lacks room for two. Reset clears the frame state (CRC preset
// to all ones) and sets collision_ignore_bits to zero; no clearing pass is needed.

module iso15693_tag_response_decoder
    import itrd_pkg::*;
#(
    parameter int MAX_RAW_BYTES = ITRD_MAX_RAW_BYTES
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,     // [7:0] raw_byte
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,     // [7:0] decoded_byte, [10:8] status, [11] crc_bad
    output logic             m_tuser,     // [0] kind
    output logic             m_tlast,
    input  logic             cfg_wr_en,
    input  logic [CIB_W-1:0] cfg_wr_data
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       fire;
    logic       room;
    step_out_t  step_out;
    result_t    out_res;

    assign fire          = in_valid_reg && room;
    assign s_tready      = !in_valid_reg || fire;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    itrd_frame_core #(
        .MAX_RAW_BYTES (MAX_RAW_BYTES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .raw_byte    (in_byte_reg),
        .frame_end   (in_last_reg),
        .step_out    (step_out)
    );

    itrd_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step_out),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {4'h0, out_res.crc_bad, out_res.status, out_res.decoded_byte};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

    // Every request that closes a frame produces its status result.
    a_status_per_frame: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_last_reg |-> step_out.count != 2'd0)
        else $error("frame end produced no result");

    a_result_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_last_reg |=> m_tvalid)
        else $error("no result pending after frame end");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == KIND_STATUS) == m_tlast)
        else $error("last flag does not match result kind");

    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_DATA) |-> m_tdata[15:8] == 8'h00)
        else $error("data result carries status bits");

endmodule
